FILE: hw/rtl/rafr_pkg.sv
`default_nettype none

package rafr_pkg;

  localparam int unsigned RING_DEPTH_DEF = 8;
  localparam int unsigned FRAME_LEN_DEF  = 8;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // register word index
  localparam logic REG_NODE_ADDRESS = 1'b0;

  // frame offsets that carry command and argument
  localparam int unsigned CODE_OFFSET = 2;
  localparam int unsigned ARG_OFFSET  = 4;

  typedef logic [7:0] byte_t;

  localparam byte_t NEWLINE_BYTE = 8'h0A;

  typedef enum logic [1:0] {
    OP_RX_BYTE  = 2'd0,
    OP_POLL     = 2'd1,
    OP_TX_PUSH  = 2'd2,
    OP_TX_READY = 2'd3
  } op_t;

  typedef struct packed {
    op_t   op;
    byte_t data;
  } item_t;

  typedef struct packed {
    logic  rx_overrun;
    logic  poll_empty;
    logic  cmd_valid;
    byte_t cmd_code;
    byte_t cmd_arg;
    logic  tx_accepted;
    logic  tx_valid;
    byte_t tx_data;
    logic  drive_enable;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rafr_ram.sv
`default_nettype none

module rafr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rafr_ring.sv
`default_nettype none

module rafr_ring #(
  parameter int unsigned DEPTH = rafr_pkg::RING_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rafr_pkg::byte_t push_data,
  input  wire logic            pop,
  input  wire logic            clear,
  output logic                 full,
  output logic                 empty,
  output rafr_pkg::byte_t      head_data
);

  import rafr_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0] head, tail;
  logic [PTR_W-1:0] head_inc, tail_inc;
  logic [PTR_W-1:0] head_next, tail_next;
  logic             byp_hit;
  byte_t            byp_data;
  byte_t            ram_q;

  always_comb begin
    head_inc  = (head == LAST) ? '0 : head + PTR_W'(1);
    tail_inc  = (tail == LAST) ? '0 : tail + PTR_W'(1);
    full      = (head_inc == tail);
    empty     = (head == tail);
    head_next = clear ? '0 : (push ? head_inc : head);
    tail_next = clear ? '0 : (pop ? tail_inc : tail);
    head_data = byp_hit ? byp_data : ram_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      byp_hit <= 1'b0;
    end else begin
      head    <= head_next;
      tail    <= tail_next;
      // write into the slot being prefetched: RAM returns old data
      byp_hit <= push && (head == tail_next);
    end
    byp_data <= push_data;
  end

  // read address runs one step ahead so the oldest byte is ready next cycle
  rafr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (head),
    .wr_data (push_data),
    .rd_addr (tail_next),
    .rd_data (ram_q)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/rafr_front.sv
`default_nettype none

module rafr_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      opcode,
  input  wire rafr_pkg::byte_t data_byte,
  output logic                 q_valid,
  output rafr_pkg::item_t      q_item,
  input  wire logic            q_take
);

  import rafr_pkg::*;

  item_t      slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;
  item_t      item_in;

  always_comb begin
    in_ready     = (count != 2'd2);
    q_valid      = (count != 2'd0);
    q_item       = slot[rd_ptr];
    push         = in_valid && in_ready;
    pop          = q_valid && q_take;
    item_in.op   = op_t'(opcode);
    item_in.data = data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      slot[wr_ptr] <= item_in;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rafr_back.sv
`default_nettype none

module rafr_back #(
  parameter int unsigned RING_DEPTH = rafr_pkg::RING_DEPTH_DEF,
  parameter int unsigned FRAME_LEN  = rafr_pkg::FRAME_LEN_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rafr_pkg::byte_t node_address,
  input  wire logic            q_valid,
  input  wire rafr_pkg::item_t q_item,
  output logic                 q_take,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rafr_pkg::result_t    res
);

  import rafr_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAME_LEN + 1);
  localparam logic [CNT_W-1:0] LEN_C  = CNT_W'(FRAME_LEN);
  localparam logic [CNT_W-1:0] CODE_C = CNT_W'(CODE_OFFSET);
  localparam logic [CNT_W-1:0] ARG_C  = CNT_W'(ARG_OFFSET);

  logic             rx_push, rx_pop, tx_push, tx_pop, clear;
  logic             rx_full, rx_empty, tx_full, tx_empty;
  byte_t            rx_head_data, tx_head_data;
  logic [CNT_W-1:0] frame_count, frame_count_next;
  logic             in_frame, in_frame_next;
  logic             drive_on, drive_on_next;
  byte_t            code_byte, code_byte_next;
  byte_t            arg_byte, arg_byte_next;
  byte_t            c;
  result_t          r;

  always_comb begin
    q_take           = q_valid && (!out_valid || out_ready);
    rx_push          = 1'b0;
    rx_pop           = 1'b0;
    tx_push          = 1'b0;
    tx_pop           = 1'b0;
    clear            = 1'b0;
    frame_count_next = frame_count;
    in_frame_next    = in_frame;
    drive_on_next    = drive_on;
    code_byte_next   = code_byte;
    arg_byte_next    = arg_byte;
    c                = rx_head_data;
    r                = '0;
    if (q_take) begin
      unique case (q_item.op)
        OP_RX_BYTE: begin
          if (rx_full) begin
            r.rx_overrun = 1'b1;
          end else begin
            rx_push = 1'b1;
          end
        end
        OP_POLL: begin
          if (rx_empty) begin
            r.poll_empty = 1'b1;
          end else begin
            rx_pop = 1'b1;
            if (c == node_address || in_frame) begin
              in_frame_next = 1'b1;
              // only offsets 2 and 4 of the frame are ever read back
              if (frame_count < LEN_C) begin
                if (frame_count == CODE_C) begin
                  code_byte_next = c;
                end
                if (frame_count == ARG_C) begin
                  arg_byte_next = c;
                end
              end
              if (c == NEWLINE_BYTE) begin
                frame_count_next = '0;
                in_frame_next    = 1'b0;
                clear            = 1'b1;
                r.cmd_valid      = 1'b1;
                r.cmd_code       = code_byte_next;
                r.cmd_arg        = arg_byte_next;
              end else if (frame_count < LEN_C) begin
                frame_count_next = frame_count + CNT_W'(1);
              end
            end
          end
        end
        OP_TX_PUSH: begin
          drive_on_next = 1'b1;
          if (!tx_full) begin
            tx_push       = 1'b1;
            r.tx_accepted = 1'b1;
          end
        end
        OP_TX_READY: begin
          if (tx_empty) begin
            drive_on_next = 1'b0;
          end else begin
            tx_pop    = 1'b1;
            r.tx_valid = 1'b1;
            r.tx_data  = tx_head_data;
          end
        end
        default: ;
      endcase
    end
    r.drive_enable = drive_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      in_frame    <= 1'b0;
      drive_on    <= 1'b0;
      code_byte   <= '0;
      arg_byte    <= '0;
      out_valid   <= 1'b0;
    end else begin
      frame_count <= frame_count_next;
      in_frame    <= in_frame_next;
      drive_on    <= drive_on_next;
      code_byte   <= code_byte_next;
      arg_byte    <= arg_byte_next;
      if (q_take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (q_take) begin
      res <= r;
    end
  end

  rafr_ring #(
    .DEPTH (RING_DEPTH)
  ) u_rx_ring (
    .clk       (clk),
    .rst       (rst),
    .push      (rx_push),
    .push_data (q_item.data),
    .pop       (rx_pop),
    .clear     (clear),
    .full      (rx_full),
    .empty     (rx_empty),
    .head_data (rx_head_data)
  );

  rafr_ring #(
    .DEPTH (RING_DEPTH)
  ) u_tx_ring (
    .clk       (clk),
    .rst       (rst),
    .push      (tx_push),
    .push_data (q_item.data),
    .pop       (tx_pop),
    .clear     (clear),
    .full      (tx_full),
    .empty     (tx_empty),
    .head_data (tx_head_data)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/rs485_addressed_frame_receiver.sv
// Half-duplex RS-485 line buffer with an addressed frame receiver. Each input
// word carries an opcode (line byte received, poll, push transmit byte,
// transmitter ready) and a data byte; each word yields exactly one result word.
// Receive and transmit rings have RING_DEPTH slots and hold RING_DEPTH-1 bytes;
// a full receive ring drops the byte and flags rx_overrun, a full transmit ring
// reports tx_accepted low. A poll pops one received byte into the framer: a
// byte equal to node_address (register 0, byte address 0) opens a frame, a
// newline closes it, returns frame bytes 2 and 4 as cmd_code/cmd_arg and
// empties both rings. Bytes past FRAME_LEN are not stored. Transmitter ready
// pops one byte, or drops drive_enable when the transmit ring is empty.
// Throughput is one word per clock unless out_ready stalls it. Each word is
// registered in the two-entry input queue, then goes combinationally through
// the execute stage, doing all its work, into the result register. The ring
// RAMs prefetch the oldest byte so a pop never waits on the read port.
// No clearing pass after reset: ring slots are only read once written.
`default_nettype none

module rs485_addressed_frame_receiver #(
  parameter int unsigned RING_DEPTH = rafr_pkg::RING_DEPTH_DEF,
  parameter int unsigned FRAME_LEN  = rafr_pkg::FRAME_LEN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // APB config port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rafr_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [rafr_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [rafr_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  // input words
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      opcode,
  input  wire logic [7:0]                      data_byte,
  // result words
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 rx_overrun,
  output logic                                 poll_empty,
  output logic                                 cmd_valid,
  output logic [7:0]                           cmd_code,
  output logic [7:0]                           cmd_arg,
  output logic                                 tx_accepted,
  output logic                                 tx_valid,
  output logic [7:0]                           tx_data,
  output logic                                 drive_enable
);

  import rafr_pkg::*;

  byte_t   node_address;
  logic    cfg_wr;
  logic    q_valid;
  item_t   q_item;
  logic    q_take;
  result_t res;

  // Config: single register, word index in paddr[2], byte lanes ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= '0;
    end else if (cfg_wr && paddr[2] == REG_NODE_ADDRESS) begin
      node_address <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_NODE_ADDRESS) begin
      prdata = {{(APB_DATA_W - 8){1'b0}}, node_address};
    end
  end

  // Front: accept and decode words into a short queue.
  rafr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .data_byte (data_byte),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take)
  );

  // Back: rings, framer and driver enable; registered result word.
  rafr_back #(
    .RING_DEPTH (RING_DEPTH),
    .FRAME_LEN  (FRAME_LEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .node_address (node_address),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_take       (q_take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .res          (res)
  );

  assign rx_overrun   = res.rx_overrun;
  assign poll_empty   = res.poll_empty;
  assign cmd_valid    = res.cmd_valid;
  assign cmd_code     = res.cmd_code;
  assign cmd_arg      = res.cmd_arg;
  assign tx_accepted  = res.tx_accepted;
  assign tx_valid     = res.tx_valid;
  assign tx_data      = res.tx_data;
  assign drive_enable = res.drive_enable;

  // One opcode per word: at most one event flag per result.
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({rx_overrun, poll_empty, cmd_valid, tx_accepted, tx_valid}))
    else $error("more than one event flag in a result word");

  // A transmit byte that entered the ring always leaves the line driven.
  a_push_drives: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tx_accepted) |-> drive_enable)
    else $error("accepted transmit byte without drive enable");

  // Payload bytes of events that did not occur read as zero.
  a_idle_bytes_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((cmd_valid || (cmd_code == 8'd0 && cmd_arg == 8'd0))
                   && (tx_valid || tx_data == 8'd0)))
    else $error("nonzero payload byte without its event");

endmodule

`default_nettype wire

FILE: verif/rafr_link_checker.sv
`default_nettype none

module rafr_link_checker #(
  parameter int unsigned SLOTS       = rafr_pkg::RING_DEPTH_DEF,
  parameter int unsigned FRAME_BYTES = rafr_pkg::FRAME_LEN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rafr_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [rafr_pkg::APB_DATA_W-1:0] pwdata,
  input  wire logic                            pready,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic [1:0]                      opcode,
  input  wire logic [7:0]                      data_byte,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic                            rx_overrun,
  input  wire logic                            poll_empty,
  input  wire logic                            cmd_valid,
  input  wire logic [7:0]                      cmd_code,
  input  wire logic [7:0]                      cmd_arg,
  input  wire logic                            tx_accepted,
  input  wire logic                            tx_valid,
  input  wire logic [7:0]                      tx_data,
  input  wire logic                            drive_enable,
  output int unsigned                          mismatches,
  output int unsigned                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rafr_pkg::*;

  byte_t       rx_mem [SLOTS];
  byte_t       tx_mem [SLOTS];
  int unsigned rx_wr, rx_rd, tx_wr, tx_rd;
  byte_t       frame_mem [FRAME_BYTES];
  int unsigned frame_fill;
  logic        framing;
  logic        driving;
  byte_t       my_address;
  result_t     expected_words [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic void clear_rings();
    for (int i = 0; i < SLOTS; i++) begin
      rx_mem[i] = '0;
      tx_mem[i] = '0;
    end
    rx_wr = 0;
    rx_rd = 0;
    tx_wr = 0;
    tx_rd = 0;
  endfunction

  // one word through the link buffer and framer
  function automatic result_t step_link(op_t op, byte_t b);
    result_t     r;
    int unsigned nx;
    byte_t       c;
    r = '0;
    case (op)
      OP_RX_BYTE: begin
        nx = (rx_wr + 1) % SLOTS;
        if (nx != rx_rd) begin
          rx_mem[rx_wr] = b;
          rx_wr = nx;
        end else begin
          r.rx_overrun = 1'b1;
        end
      end
      OP_POLL: begin
        if (rx_wr == rx_rd) begin
          r.poll_empty = 1'b1;
        end else begin
          c = rx_mem[rx_rd];
          rx_rd = (rx_rd + 1) % SLOTS;
          if (c == my_address || framing) begin
            framing = 1'b1;
            if (frame_fill < FRAME_BYTES) frame_mem[frame_fill] = c;
            if (c == NEWLINE_BYTE) begin
              frame_fill  = 0;
              framing     = 1'b0;
              r.cmd_valid = 1'b1;
              r.cmd_code  = frame_mem[CODE_OFFSET];
              r.cmd_arg   = frame_mem[ARG_OFFSET];
              clear_rings();
            end else if (frame_fill < FRAME_BYTES) begin
              frame_fill++;
            end
          end
        end
      end
      OP_TX_PUSH: begin
        nx = (tx_wr + 1) % SLOTS;
        if (nx != tx_rd) begin
          tx_mem[tx_wr] = b;
          tx_wr = nx;
          r.tx_accepted = 1'b1;
        end
        driving = 1'b1;
      end
      default: begin
        if (tx_wr == tx_rd) begin
          driving = 1'b0;
        end else begin
          r.tx_data  = tx_mem[tx_rd];
          tx_rd      = (tx_rd + 1) % SLOTS;
          r.tx_valid = 1'b1;
        end
      end
    endcase
    r.drive_enable = driving;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_rings();
      for (int i = 0; i < FRAME_BYTES; i++) frame_mem[i] = '0;
      frame_fill = 0;
      framing    = 1'b0;
      driving    = 1'b0;
      my_address = '0;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[APB_ADDR_W-1:2] == REG_NODE_ADDRESS)
        my_address = pwdata[7:0];
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("rx_overrun",   want.rx_overrun,   rx_overrun);
          check_field("poll_empty",   want.poll_empty,   poll_empty);
          check_field("cmd_valid",    want.cmd_valid,    cmd_valid);
          check_field("cmd_code",     want.cmd_code,     cmd_code);
          check_field("cmd_arg",      want.cmd_arg,      cmd_arg);
          check_field("tx_accepted",  want.tx_accepted,  tx_accepted);
          check_field("tx_valid",     want.tx_valid,     tx_valid);
          check_field("tx_data",      want.tx_data,      tx_data);
          check_field("drive_enable", want.drive_enable, drive_enable);
        end
      end
      if (in_valid && in_ready)
        expected_words.push_back(step_link(op_t'(opcode), data_byte));
    end
    pending = expected_words.size();
  end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rafr_pkg::*;

  // generous bound on the whole run
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  // two-stage pipe, plus margin
  localparam int unsigned DRAIN_CYCLES = 8;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic                  in_valid  = 1'b0;
  logic [1:0]            opcode    = '0;
  logic [7:0]            data_byte = '0;
  logic                  out_ready = 1'b0;

  wire logic [APB_DATA_W-1:0] prdata;
  wire logic                  pready;
  wire logic                  in_ready;
  wire logic                  out_valid;
  wire logic                  rx_overrun;
  wire logic                  poll_empty;
  wire logic                  cmd_valid;
  wire logic [7:0]            cmd_code;
  wire logic [7:0]            cmd_arg;
  wire logic                  tx_accepted;
  wire logic                  tx_valid;
  wire logic [7:0]            tx_data;
  wire logic                  drive_enable;

  int unsigned link_mismatches;
  int unsigned link_pending;

  // idle odds in percent, per cycle; changed only between phases
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 67;
  int unsigned words_sent    = 0;
  int unsigned cycle_count   = 0;
  // node address currently programmed, used to build frames
  byte_t       node_addr     = '0;

  rs485_addressed_frame_receiver DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rx_overrun   (rx_overrun),
    .poll_empty   (poll_empty),
    .cmd_valid    (cmd_valid),
    .cmd_code     (cmd_code),
    .cmd_arg      (cmd_arg),
    .tx_accepted  (tx_accepted),
    .tx_valid     (tx_valid),
    .tx_data      (tx_data),
    .drive_enable (drive_enable)
  );

  rafr_link_checker link_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rx_overrun   (rx_overrun),
    .poll_empty   (poll_empty),
    .cmd_valid    (cmd_valid),
    .cmd_code     (cmd_code),
    .cmd_arg      (cmd_arg),
    .tx_accepted  (tx_accepted),
    .tx_valid     (tx_valid),
    .tx_data      (tx_data),
    .drive_enable (drive_enable),
    .mismatches   (link_mismatches),
    .pending      (link_pending)
  );

  initial forever #1 clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  initial forever begin
    @(negedge clk);
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Called at a falling edge, returns at the falling edge after acceptance.
  // Valid only goes low in a sender gap, so it is assigned once per step.
  task automatic send_word(op_t op, byte_t d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= d;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
  endtask

  // Stop the sender and let every pending result word drain out.
  task automatic drain();
    in_valid <= 1'b0;
    while (link_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write: setup then access; the write lands when pready is seen high.
  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, byte_t val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= {24'($urandom), val};   // upper bits are don't-care
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Only touch the register with the block idle.
  task automatic set_node_address(byte_t addr);
    drain();
    apb_write({REG_NODE_ADDRESS, 2'b00}, addr);
    node_addr = addr;
  endtask

  // Frame body byte: mostly anything but newline, now and then the address.
  function automatic byte_t body_byte();
    byte_t b;
    b = byte_t'($urandom);
    if (b == NEWLINE_BYTE) b = b ^ 8'h01;
    if ($urandom_range(0, 15) == 0) b = node_addr;
    return b;
  endfunction

  // Feed bytes onto the line and poll them out in small batches, so the
  // receive ring never runs over on its own. Stray transmit traffic is mixed in.
  task automatic send_line_bytes(byte_t seq [$]);
    int unsigned held;
    int unsigned hold_max;
    held     = 0;
    hold_max = $urandom_range(1, 4);
    foreach (seq[i]) begin
      send_word(OP_RX_BYTE, seq[i]);
      held++;
      if ($urandom_range(0, 99) < 12)
        send_word($urandom_range(0, 1) ? OP_TX_PUSH : OP_TX_READY, byte_t'($urandom));
      if (held >= hold_max || $urandom_range(0, 99) < 50) begin
        repeat (held) send_word(OP_POLL, byte_t'($urandom));
        held     = 0;
        hold_max = $urandom_range(1, 4);
      end
    end
    repeat (held) send_word(OP_POLL, byte_t'($urandom));
    // occasional poll of an empty ring
    if ($urandom_range(0, 99) < 20) send_word(OP_POLL, byte_t'($urandom));
  endtask

  // Random traffic: mostly well-formed frames, some transmit bursts,
  // broken frames and single noise words.
  task automatic random_phase(int unsigned n_words);
    byte_t       seq [$];
    int unsigned pick;
    int unsigned len;
    int unsigned target;
    target = words_sent + n_words;
    while (words_sent < target) begin
      pick = $urandom_range(0, 99);
      seq.delete();
      if (pick < 55) begin
        // addressed frame; a quarter run past the frame store
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 11) : $urandom_range(0, 6);
        seq.push_back(node_addr);
        repeat (len) seq.push_back(body_byte());
        seq.push_back(NEWLINE_BYTE);
        send_line_bytes(seq);
      end else if (pick < 70) begin
        // transmit burst, may fill the ring and run it dry
        repeat ($urandom_range(1, 9)) send_word(OP_TX_PUSH, byte_t'($urandom));
        repeat ($urandom_range(1, 10)) send_word(OP_TX_READY, byte_t'($urandom));
      end else if (pick < 85) begin
        // broken: stray address, early newline, junk
        len = $urandom_range(1, 8);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0:       seq.push_back(node_addr);
            1:       seq.push_back(NEWLINE_BYTE);
            default: seq.push_back(byte_t'($urandom));
          endcase
        end
        send_line_bytes(seq);
      end else begin
        send_word(op_t'($urandom_range(0, 3)), byte_t'($urandom));
      end
    end
  endtask

  initial begin
    byte_t tx_fill [8];
    byte_t rx_fill [8];
    tx_fill = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hAA, 8'h55, 8'h12};
    rx_fill = '{8'h3C, 8'h11, 8'hC3, 8'h22, 8'hA5, 8'h33, NEWLINE_BYTE, 8'hEE};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed part, sender 17% / receiver 67% idle ----
    set_node_address(8'h3C);
    send_word(OP_POLL, 8'hFF);       // poll with empty receive ring
    send_word(OP_TX_READY, 8'h00);   // transmitter ready, empty ring: drive stays off
    // seven pushes fill the transmit ring, the eighth is refused
    foreach (tx_fill[i]) send_word(OP_TX_PUSH, tx_fill[i]);
    send_word(OP_TX_READY, 8'hFF);   // pops the first queued byte
    // address, frame body and newline fill the receive ring; last byte overruns
    foreach (rx_fill[i]) send_word(OP_RX_BYTE, rx_fill[i]);
    // polls run the frame; the newline yields code C3, arg A5 and clears rings
    repeat (7) send_word(OP_POLL, 8'h00);
    send_word(OP_TX_READY, 8'h5A);   // transmit ring was cleared: drive drops

    // ---- random, sender 17% / receiver 67% idle, lowest address ----
    set_node_address(8'h00);
    random_phase(450);

    // ---- swap the idle odds, highest address ----
    send_idle_pct = 67;
    recv_idle_pct = 17;
    set_node_address(8'hFF);
    random_phase(450);

    // ---- no idling, random address ----
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_node_address(byte_t'($urandom_range(1, 254)));
    random_phase(300);

    // address equal to newline: a frame opens and closes on one byte
    set_node_address(NEWLINE_BYTE);
    random_phase(200);

    drain();
    if (link_mismatches == 0 && link_pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
